FILE: rtl/incp_pkg.sv
// Shared widths, types and helpers for the incircle predicate pipeline.
// Depends on nothing; every other file imports it.
package incp_pkg;

	// Coordinate width of the input fields.
	localparam int COORD_WIDTH = 16;

	// A coordinate difference needs one bit more than a coordinate.
	localparam int DIFF_W = COORD_WIDTH + 1;
	// Signed product of two differences.
	localparam int PROD_W = 2 * DIFF_W;
	// Magnitude of a lifted term or of a 2x2 cross term.
	localparam int MAG_W  = 2 * COORD_WIDTH + 2;
	// Halves used to split the wide lift-times-cross multiplication.
	localparam int HALF_W = (MAG_W + 1) / 2;
	localparam int PAD_W  = 2 * HALF_W;
	// Magnitude of one lift-times-cross product.
	localparam int TERM_W = 2 * PAD_W;
	// The full determinant, with headroom for the three-way sum and sign.
	localparam int DET_W  = TERM_W + 3;

	typedef logic [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [HALF_W-1:0]        half_t;
	typedef logic [PAD_W-1:0]         part_t;
	typedef logic [TERM_W-1:0]        term_t;
	typedef logic signed [DET_W-1:0]  det_t;

	// Differences against the query point (rows) and against vertex c.
	typedef struct packed {
		diff_t [2:0] mx;
		diff_t [2:0] my;
		diff_t [1:0] ox;
		diff_t [1:0] oy;
	} diffs_t;

	// Lifted terms, cross terms in sign-magnitude form and the orientation.
	typedef struct packed {
		mag_t [2:0] lift;
		mag_t [2:0] cross_mag;
		logic [2:0] cross_neg;
		logic       ccw;
	} minors_t;

	// Exact signed difference of two coordinates.
	function automatic diff_t coord_sub(input coord_t a, input coord_t b);
		diff_t ea;
		diff_t eb;
		ea = diff_t'({a[COORD_WIDTH-1], a});
		eb = diff_t'({b[COORD_WIDTH-1], b});
		return ea - eb;
	endfunction

endpackage

FILE: rtl/incp_diff.sv
// First pipeline stage: coordinate differences for both determinants.
// Depends on incp_pkg.
module incp_diff import incp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  coord_t ax,
	input  coord_t ay,
	input  coord_t bx,
	input  coord_t by,
	input  coord_t cx,
	input  coord_t cy,
	input  coord_t px,
	input  coord_t py,
	output logic   valid_s1,
	output diffs_t diffs_s1
);

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Vertices relative to the query point, and a, b relative to c.
	always_ff @(posedge clk) begin
		diffs_s1.mx[0] <= coord_sub(ax, px);
		diffs_s1.my[0] <= coord_sub(ay, py);
		diffs_s1.mx[1] <= coord_sub(bx, px);
		diffs_s1.my[1] <= coord_sub(by, py);
		diffs_s1.mx[2] <= coord_sub(cx, px);
		diffs_s1.my[2] <= coord_sub(cy, py);
		diffs_s1.ox[0] <= coord_sub(ax, cx);
		diffs_s1.oy[0] <= coord_sub(ay, cy);
		diffs_s1.ox[1] <= coord_sub(bx, cx);
		diffs_s1.oy[1] <= coord_sub(by, cy);
	end

endmodule

FILE: rtl/incp_minor.sv
// Stages two and three: squares and 2x2 products, then lifted terms,
// cross terms in sign-magnitude form and the orientation flag. Uses incp_pkg.
module incp_minor import incp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  diffs_t  diffs_s1,
	output logic    valid_s3,
	output minors_t minors_s3
);

	logic             valid_s2;
	prod_t [2:0]      sqx_s2;
	prod_t [2:0]      sqy_s2;
	prod_t [2:0]      crp_s2;
	prod_t [2:0]      crn_s2;
	prod_t            orp_s2;
	prod_t            orn_s2;

	prod_t [2:0]      cr_fwd;
	prod_t [2:0]      cr_rev;
	prod_t            orient;

	// Valid bits of stages two and three.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage two: every product of two differences, one multiplier each.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sqx_s2[k] <= $signed(diffs_s1.mx[k]) * $signed(diffs_s1.mx[k]);
			sqy_s2[k] <= $signed(diffs_s1.my[k]) * $signed(diffs_s1.my[k]);
		end
		// Cross term k uses the two other rows in cyclic order.
		crp_s2[0] <= $signed(diffs_s1.mx[1]) * $signed(diffs_s1.my[2]);
		crn_s2[0] <= $signed(diffs_s1.my[1]) * $signed(diffs_s1.mx[2]);
		crp_s2[1] <= $signed(diffs_s1.mx[2]) * $signed(diffs_s1.my[0]);
		crn_s2[1] <= $signed(diffs_s1.my[2]) * $signed(diffs_s1.mx[0]);
		crp_s2[2] <= $signed(diffs_s1.mx[0]) * $signed(diffs_s1.my[1]);
		crn_s2[2] <= $signed(diffs_s1.my[0]) * $signed(diffs_s1.mx[1]);
		orp_s2    <= $signed(diffs_s1.ox[0]) * $signed(diffs_s1.oy[1]);
		orn_s2    <= $signed(diffs_s1.oy[0]) * $signed(diffs_s1.ox[1]);
	end

	// Both signs of each cross term are formed side by side.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cr_fwd[k] = crp_s2[k] - crn_s2[k];
			cr_rev[k] = crn_s2[k] - crp_s2[k];
		end
		orient = orp_s2 - orn_s2;
	end

	// Stage three: lifted sums, cross magnitudes and the orientation flag.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			minors_s3.lift[k]      <= mag_t'(sqx_s2[k]) + mag_t'(sqy_s2[k]);
			minors_s3.cross_neg[k] <= cr_fwd[k][PROD_W-1];
			minors_s3.cross_mag[k] <= cr_fwd[k][PROD_W-1] ? mag_t'(cr_rev[k])
			                                               : mag_t'(cr_fwd[k]);
		end
		minors_s3.ccw <= !orient[PROD_W-1] && (orient != '0);
	end

endmodule

FILE: rtl/incp_lift.sv
// Stages four to seven: lift-times-cross products split into half-width
// partial products, their recombination, the signed sum and the decision.
// Uses incp_pkg.
module incp_lift import incp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s3,
	input  minors_t minors_s3,
	output logic    done,
	output logic    inside_circle,
	output logic    counter_clockwise
);

	logic              valid_s4;
	logic              valid_s5;
	logic              valid_s6;
	part_t [2:0]       pp_ll_s4;
	part_t [2:0]       pp_lh_s4;
	part_t [2:0]       pp_hl_s4;
	part_t [2:0]       pp_hh_s4;
	logic  [2:0]       neg_s4;
	logic              ccw_s4;
	term_t [2:0]       term_s5;
	logic  [2:0]       neg_s5;
	logic              ccw_s5;
	det_t              det_s6;
	logic              ccw_s6;

	part_t [2:0]       lift_pad;
	part_t [2:0]       cross_pad;
	logic  [HALF_W:0]  mid_sum [3];
	det_t              det_next;

	// Valid bits down to the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done     <= valid_s6;
		end
	end

	// Operands padded to two equal halves.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lift_pad[k]  = part_t'(minors_s3.lift[k]);
			cross_pad[k] = part_t'(minors_s3.cross_mag[k]);
		end
	end

	// Stage four: four half-width partial products per term.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pp_ll_s4[k] <= lift_pad[k][HALF_W-1:0] * cross_pad[k][HALF_W-1:0];
			pp_lh_s4[k] <= lift_pad[k][HALF_W-1:0] * cross_pad[k][PAD_W-1:HALF_W];
			pp_hl_s4[k] <= lift_pad[k][PAD_W-1:HALF_W] * cross_pad[k][HALF_W-1:0];
			pp_hh_s4[k] <= lift_pad[k][PAD_W-1:HALF_W] * cross_pad[k][PAD_W-1:HALF_W];
		end
		neg_s4 <= minors_s3.cross_neg;
		ccw_s4 <= minors_s3.ccw;
	end

	// The upper halves of the two middle partial products are summed before the wide add.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mid_sum[k] = (HALF_W+1)'(pp_lh_s4[k][PAD_W-1:HALF_W])
			           + (HALF_W+1)'(pp_hl_s4[k][PAD_W-1:HALF_W]);
		end
	end

	// Stage five: the outer products do not overlap, so they concatenate.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			term_s5[k] <= {pp_hh_s4[k], pp_ll_s4[k]}
			            + (term_t'(pp_lh_s4[k][HALF_W-1:0]) << HALF_W)
			            + (term_t'(pp_hl_s4[k][HALF_W-1:0]) << HALF_W)
			            + (term_t'(mid_sum[k]) << PAD_W);
		end
		neg_s5 <= neg_s4;
		ccw_s5 <= ccw_s4;
	end

	// Signed sum: negated terms are inverted and their carries added in.
	always_comb begin
		det_next = '0;
		for (int k = 0; k < 3; k++) begin
			det_next = det_next + (det_t'(term_s5[k]) ^ {DET_W{neg_s5[k]}})
			         + det_t'(neg_s5[k]);
		end
	end

	// Stage six: the full determinant.
	always_ff @(posedge clk) begin
		det_s6 <= det_next;
		ccw_s6 <= ccw_s5;
	end

	// Output stage: the sign test follows the orientation.
	always_ff @(posedge clk) begin
		counter_clockwise <= ccw_s6;
		if (ccw_s6) begin
			inside_circle <= !det_s6[DET_W-1] && (det_s6 != '0);
		end else begin
			inside_circle <= det_s6[DET_W-1];
		end
	end

endmodule

FILE: rtl/incircle_predicate.sv
// Top level of the exact incircle predicate pipeline.
// Depends on incp_pkg, incp_diff, incp_minor and incp_lift.
//
// Usage:
// A request carries the three triangle vertices a, b, c and a query point p.
// It is taken at a rising edge where start is high and busy is low; busy is
// held low, so a request can be taken at every edge.
// The result is on inside_circle and counter_clockwise for exactly one cycle,
// marked by done. A request passes through seven pipeline registers on its
// way to done; the pipeline gives one result per cycle.
// The depth is set by the split of the wide lift-times-cross product into
// half-width partial products and by their recombination and summing.
// counter_clockwise is 1 when the orientation of a, b, c is strictly
// positive. inside_circle is 1 when the incircle determinant is strictly
// positive for such a triangle, or strictly negative otherwise.
// The arithmetic is exact, so no input can overflow it.
// Reset clears the valid bits; requests in flight are dropped and done stays
// low until new requests have passed through. The receiver cannot stall.
module incircle_predicate import incp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] vertex_a_x,
	input  logic [COORD_WIDTH-1:0] vertex_a_y,
	input  logic [COORD_WIDTH-1:0] vertex_b_x,
	input  logic [COORD_WIDTH-1:0] vertex_b_y,
	input  logic [COORD_WIDTH-1:0] vertex_c_x,
	input  logic [COORD_WIDTH-1:0] vertex_c_y,
	input  logic [COORD_WIDTH-1:0] query_x,
	input  logic [COORD_WIDTH-1:0] query_y,
	output logic                   done,
	output logic                   inside_circle,
	output logic                   counter_clockwise
);

	logic    valid_s1;
	diffs_t  diffs_s1;
	logic    valid_s3;
	minors_t minors_s3;
	logic    take;

	// The pipeline never stalls, so every request is taken.
	assign busy = 1'b0;
	assign take = start && !busy;

	// Coordinate differences.
	incp_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (take),
		.ax       (vertex_a_x),
		.ay       (vertex_a_y),
		.bx       (vertex_b_x),
		.by       (vertex_b_y),
		.cx       (vertex_c_x),
		.cy       (vertex_c_y),
		.px       (query_x),
		.py       (query_y),
		.valid_s1 (valid_s1),
		.diffs_s1 (diffs_s1)
	);

	// Lifted terms, cross terms and orientation.
	incp_minor u_minor (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.diffs_s1  (diffs_s1),
		.valid_s3  (valid_s3),
		.minors_s3 (minors_s3)
	);

	// Determinant and decision.
	incp_lift u_lift (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s3          (valid_s3),
		.minors_s3         (minors_s3),
		.done              (done),
		.inside_circle     (inside_circle),
		.counter_clockwise (counter_clockwise)
	);

endmodule
